// ----- rtl/md5_pkg.sv -----
// package with md5 constants, step tables and shared functions
package md5_pkg;

   localparam int unsigned BlockBytes = 64;
   localparam int unsigned AddrWidth = $clog2(BlockBytes);
   localparam int unsigned CountWidth = 61;

   localparam logic [31:0] InitA = 32'h67452301;
   localparam logic [31:0] InitB = 32'hefcdab89;
   localparam logic [31:0] InitC = 32'h98badcfe;
   localparam logic [31:0] InitD = 32'h10325476;

   localparam logic [7:0] PadByte = 8'h80;
   localparam logic [AddrWidth-1:0] LengthStart = AddrWidth'(56);
   localparam logic [AddrWidth-1:0] LastPos = AddrWidth'(63);

   localparam logic [31:0] StepConst [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam logic [4:0] RotAmount [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   // message word index used at a given step
   function automatic logic [3:0] word_index(input logic [5:0] step);
      logic [3:0] lo;
      lo = step[3:0];
      case (step[5:4])
         2'd0: word_index = lo;
         2'd1: word_index = 4'((lo * 5) + 1);
         2'd2: word_index = 4'((lo * 3) + 5);
         default: word_index = 4'(lo * 7);
      endcase
   endfunction

   // round function of b, c, d
   function automatic logic [31:0] round_func(input logic [1:0] round,
                                              input logic [31:0] b,
                                              input logic [31:0] c,
                                              input logic [31:0] d);
      case (round)
         2'd0: round_func = (b & c) | (~b & d);
         2'd1: round_func = (b & d) | (c & ~d);
         2'd2: round_func = b ^ c ^ d;
         default: round_func = c ^ (b | ~d);
      endcase
   endfunction

   // byte-swap a chaining word into digest byte order
   function automatic logic [31:0] swap_bytes(input logic [31:0] w);
      swap_bytes = {w[7:0], w[15:8], w[23:16], w[31:24]};
   endfunction

endpackage

// ----- rtl/md5_ram.sv -----
// generic simple dual-port ram (one write port, one read port) with registered read
module md5_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/md5_stream_hasher.sv -----
// md5 stream hasher top level: byte gathering, padding and compression sequencer
//
// Computes the MD5 digest of a byte stream. Each request transfer may carry one
// byte (tuser bit 0) and may end the message (tlast). Bytes go into a 64-byte
// block RAM; after a byte that neither completes a block nor ends the message,
// req_tready stays high. The 64th byte of a block starts a compression: one
// shared adder/rotate unit runs each MD5 step in ST_STEP after ST_RD0 to ST_RD3
// read the message word from the byte RAM one byte at a time, then ST_FOLD adds
// into the chaining words, while req_tready is low. At end of message padding
// and length are written one byte a cycle from the fill position to the end of
// the block, each padded block is compressed, and the digest is offered on rsp;
// the next request is taken once it is transferred. No clearing pass is needed
// after reset.
module md5_stream_hasher (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte
   input  logic         req_tuser,   // has_byte
   input  logic         req_tlast,   // end_of_message
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata    // digest_front [63:0], digest_back [127:64]
);
   import md5_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_STEP, ST_FOLD,
      ST_PAD, ST_LEN, ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic [31:0] a_ff, b_ff, c_ff, d_ff, a_in, b_in, c_in, d_in;
   logic [31:0] h_ff [4];
   logic [31:0] h_in [4];
   logic [CountWidth-1:0] count_ff, count_in;
   logic [5:0] step_ff, step_in;
   logic [AddrWidth-1:0] pos_ff, pos_in;
   logic [31:0] word_ff, word_in;
   logic finishing_ff, finishing_in;   // compression is part of the final padding
   logic second_ff, second_in;         // padding needs a further block
   logic marker_done_ff, marker_done_in;   // marker already written for this message
   logic [127:0] digest_ff, digest_in;
   logic [63:0] bit_len;

   logic wr_en;
   logic [AddrWidth-1:0] wr_addr, rd_addr;
   logic [7:0] wr_data, rd_data;

   md5_ram #(.Width(8), .Depth(BlockBytes)) u_block (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   logic [3:0] g;
   logic [31:0] t_sum, t_rot;
   logic [4:0] s;
   logic accept;

   assign g = word_index(step_ff);
   assign s = RotAmount[{step_ff[5:4], step_ff[1:0]}];
   assign bit_len = {count_ff, 3'b000};
   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata = digest_ff;

   // shared step unit: add chain then rotate
   always_comb begin
      t_sum = a_ff + round_func(step_ff[5:4], b_ff, c_ff, d_ff)
            + {rd_data, word_ff[31:8]} + StepConst[step_ff];
      t_rot = (t_sum << s) | (t_sum >> (6'd32 - {1'b0, s}));
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff;
      h_in = h_ff;
      count_in = count_ff;
      step_in = step_ff;
      pos_in = pos_ff;
      word_in = word_ff;
      finishing_in = finishing_ff;
      second_in = second_ff;
      digest_in = digest_ff;
      wr_en = 1'b0;
      wr_addr = pos_ff;
      wr_data = req_tdata;
      rd_addr = {g, 2'd0};
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pos_in = count_ff[AddrWidth-1:0];
               if (req_tuser) begin
                  wr_en = 1'b1;
                  wr_addr = count_ff[AddrWidth-1:0];
                  count_in = count_ff + 1'b1;
                  pos_in = count_in[AddrWidth-1:0];
               end
               finishing_in = req_tlast;
               if (req_tuser && count_ff[AddrWidth-1:0] == LastPos) begin
                  // message ending on a full block pads a fresh block afterwards
                  second_in = req_tlast;
                  a_in = h_ff[0]; b_in = h_ff[1]; c_in = h_ff[2]; d_in = h_ff[3];
                  step_in = '0;
                  state_in = ST_RD0;
               end else if (req_tlast) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_RD0: begin
            rd_addr = {g, 2'd0};
            state_in = ST_RD1;
         end
         ST_RD1: begin
            rd_addr = {g, 2'd1};
            word_in = {rd_data, word_ff[31:8]};
            state_in = ST_RD2;
         end
         ST_RD2: begin
            rd_addr = {g, 2'd2};
            word_in = {rd_data, word_ff[31:8]};
            state_in = ST_RD3;
         end
         ST_RD3: begin
            rd_addr = {g, 2'd3};
            word_in = {rd_data, word_ff[31:8]};
            state_in = ST_STEP;
         end
         ST_STEP: begin
            a_in = d_ff;
            d_in = c_ff;
            c_in = b_ff;
            b_in = b_ff + t_rot;
            step_in = step_ff + 1'b1;
            state_in = (step_ff == 6'd63) ? ST_FOLD : ST_RD0;
         end
         ST_FOLD: begin
            h_in[0] = h_ff[0] + a_ff;
            h_in[1] = h_ff[1] + b_ff;
            h_in[2] = h_ff[2] + c_ff;
            h_in[3] = h_ff[3] + d_ff;
            if (!finishing_ff) begin
               state_in = ST_IDLE;
            end else if (second_ff) begin
               second_in = 1'b0;
               pos_in = '0;
               state_in = ST_PAD;
            end else begin
               digest_in = {swap_bytes(h_in[2]), swap_bytes(h_in[3]),
                            swap_bytes(h_in[0]), swap_bytes(h_in[1])};
               h_in[0] = InitA; h_in[1] = InitB; h_in[2] = InitC; h_in[3] = InitD;
               count_in = '0;
               state_in = ST_OUT;
            end
         end
         ST_PAD: begin
            // first pad transfer writes the marker, then zeros up to the length
            wr_en = 1'b1;
            wr_addr = pos_ff;
            wr_data = (pos_ff == count_ff[AddrWidth-1:0] && !second_ff && !marker_done_ff)
                    ? PadByte : 8'h00;
            pos_in = pos_ff + 1'b1;
            if (pos_ff == LastPos) begin
               second_in = 1'b1;
               a_in = h_ff[0]; b_in = h_ff[1]; c_in = h_ff[2]; d_in = h_ff[3];
               step_in = '0;
               state_in = ST_RD0;
            end else if (pos_ff == LengthStart - 1'b1 &&
                         (marker_done_ff || (count_ff[AddrWidth-1:0] < LengthStart))) begin
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            wr_en = 1'b1;
            wr_addr = pos_ff;
            wr_data = bit_len[8*pos_ff[2:0] +: 8];
            pos_in = pos_ff + 1'b1;
            if (pos_ff == LastPos) begin
               second_in = 1'b0;
               a_in = h_ff[0]; b_in = h_ff[1]; c_in = h_ff[2]; d_in = h_ff[3];
               step_in = '0;
               state_in = ST_RD0;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // marker tracking across the padding blocks
   always_comb begin
      marker_done_in = marker_done_ff;
      if (state_ff == ST_PAD && pos_ff == count_ff[AddrWidth-1:0]) begin
         marker_done_in = 1'b1;
      end
      if (state_ff == ST_OUT || state_ff == ST_IDLE) begin
         marker_done_in = 1'b0;
      end
   end

   // state and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         h_ff[0] <= InitA; h_ff[1] <= InitB; h_ff[2] <= InitC; h_ff[3] <= InitD;
         count_ff <= '0;
         finishing_ff <= 1'b0;
         second_ff <= 1'b0;
         marker_done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         h_ff <= h_in;
         count_ff <= count_in;
         finishing_ff <= finishing_in;
         second_ff <= second_in;
         marker_done_ff <= marker_done_in;
      end
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in;
      step_ff <= step_in;
      pos_ff <= pos_in;
      word_ff <= word_in;
      digest_ff <= digest_in;
   end

`ifndef ASSERT_OFF
   // never ready while a digest waits
   a_no_ready_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("ready during output");
   // digest holds until transferred
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("digest dropped");
   // count is zero while a digest is offered
   a_count_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> count_ff == '0) else $error("count not cleared");
`endif

endmodule
